/* hdl/abc_pkg.sv */
// ----------------------------------------------------------------------------
// abc_pkg
// Shared types, register indexes, blend mode codes and the divide-by-255
// helpers of the alpha blend compositor.
// ----------------------------------------------------------------------------
package abc_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned DIV_STAGES = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND_MODE    = 1'b0,
    REG_LAYER_OPACITY = 1'b1
  } cfg_reg_t;

  // blend mode codes, codes 6 and 7 pass the destination through
  typedef enum logic [2:0] {
    MODE_OPAQUE    = 3'd0,
    MODE_STRAIGHT  = 3'd1,
    MODE_PREMULT   = 3'd2,
    MODE_PREM_OPQ  = 3'd3,
    MODE_DEST_OVER = 3'd4,
    MODE_COVERAGE  = 3'd5
  } blend_mode_t;

  localparam logic [2:0] MODE_RESET    = 3'd1;
  localparam logic [7:0] OPACITY_RESET = 8'hFF;
  localparam logic [7:0] CHAN_MAX      = 8'hFF;

  // floor(y / 255) for y below 65535, by reciprocal and correction
  function automatic logic [8:0] div255_floor(input logic [16:0] y);
    logic [17:0] t;
    logic [17:0] r;
    t = {1'b0, y} + 18'd1;
    r = (t + (t >> 8)) >> 8;
    return r[8:0];
  endfunction

  // rounded divide of an 8x8 product: (x + 127) / 255
  function automatic logic [7:0] rdiv(input logic [15:0] x);
    logic [16:0] y;
    logic [8:0]  q;
    y = {1'b0, x} + 17'd127;
    q = div255_floor(y);
    return q[7:0];
  endfunction

  // clamp a 9-bit channel to 255
  function automatic logic [7:0] sat8(input logic [8:0] x);
    return x[8] ? CHAN_MAX : x[7:0];
  endfunction

endpackage

/* hdl/abc_stream_if.sv */
// ----------------------------------------------------------------------------
// abc stream interfaces
// Valid/ready channels for the input pixel words and the result words.
// ----------------------------------------------------------------------------
interface abc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] dest_pixel;
  logic [31:0] src_pixel;
  logic [7:0]  coverage;

  modport source (output valid, output dest_pixel, output src_pixel, output coverage,
                  input ready);
  modport sink   (input valid, input dest_pixel, input src_pixel, input coverage,
                  output ready);
endinterface

interface abc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_pixel;

  modport source (output valid, output result_pixel, input ready);
  modport sink   (input valid, input result_pixel, output ready);
endinterface

/* hdl/alpha_blend_compositor_core.sv */
// ----------------------------------------------------------------------------
// alpha_blend_compositor_core
// Six-mode ABGR pixel compositor, one pixel per clock unless the output stalls, fully pipelined.
// ----------------------------------------------------------------------------
// One pixel word enters per clock while the pipe advances, and its result
// passes 5 arithmetic stages, an 8-stage restoring divider for the
// unpremultiply step, then the output register; every mode runs through the
// same pipe so results keep input order. The whole pipe advances whenever the
// output register is empty or being taken, so throughput is one word per
// clock with no stall on the sink side. blend_mode and layer_opacity are
// sampled as a word enters; write them only while the pipe is empty.
module alpha_blend_compositor_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [abc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abc_pkg::CFG_DATA_W-1:0] cfg_data,
  abc_in_if.sink                        in_word,
  abc_out_if.source                     out_word
);
  import abc_pkg::*;

  typedef struct packed {
    logic            valid;
    logic            use_div;
    logic [31:0]     direct;
    logic [7:0]      ra;
    logic [2:0][16:0] rem;
    logic [2:0][7:0] q;
    logic [2:0]      sat;
  } dv_t;

  // configuration registers
  logic [2:0] mode_r;
  logic [7:0] opacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RESET;
      opacity_r <= OPACITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLEND_MODE:    mode_r    <= cfg_data[2:0];
        REG_LAYER_OPACITY: opacity_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance
  logic adv;
  logic out_valid_r;
  logic [31:0] out_pixel_r;

  assign adv           = !out_valid_r || out_word.ready;
  assign in_word.ready = adv;

  // stage a: effective source alpha
  logic        a_valid_r;
  logic [31:0] a_d_r, a_s_r;
  logic [7:0]  a_sa_r;
  logic [2:0]  a_mode_r;
  logic [7:0]  a_mul;
  logic [15:0] a_prod;
  logic [7:0]  a_sa_nxt;

  always_comb begin
    a_mul  = (mode_r == MODE_COVERAGE) ? in_word.coverage : opacity_r;
    a_prod = 16'(in_word.src_pixel[31:24]) * 16'(a_mul);
    if (mode_r == MODE_STRAIGHT || mode_r == MODE_COVERAGE) begin
      a_sa_nxt = rdiv(a_prod);
    end else begin
      a_sa_nxt = in_word.src_pixel[31:24];
    end
  end

  // stage b: products
  logic        b_valid_r;
  logic [31:0] b_d_r, b_s_r;
  logic [7:0]  b_sa_r;
  logic [2:0]  b_mode_r;
  logic [2:0][15:0] b_ps_r, b_pd_r, b_pdd_r, b_psd_r;
  logic [15:0] b_pa1_r, b_pa2_r;
  logic [2:0][15:0] b_ps_nxt, b_pd_nxt, b_pdd_nxt, b_psd_nxt;
  logic [7:0]  b_inv, b_ida;

  always_comb begin
    b_inv = CHAN_MAX - a_sa_r;
    b_ida = CHAN_MAX - a_d_r[31:24];
    for (int k = 0; k < 3; k++) begin
      b_ps_nxt[k]  = 16'(a_s_r[8*k +: 8]) * 16'(a_sa_r);
      b_pd_nxt[k]  = 16'(a_d_r[8*k +: 8]) * 16'(b_inv);
      b_pdd_nxt[k] = 16'(a_d_r[8*k +: 8]) * 16'(a_d_r[31:24]);
      b_psd_nxt[k] = 16'(a_s_r[8*k +: 8]) * 16'(b_ida);
    end
  end

  // stage c: rounded quotients
  logic        c_valid_r;
  logic [31:0] c_d_r, c_s_r;
  logic [7:0]  c_sa_r;
  logic [2:0]  c_mode_r;
  logic [2:0][7:0] c_rs_r, c_rd_r, c_rdd_r, c_rsd_r;
  logic [2:0][8:0] c_tr_r;
  logic [8:0]  c_ra_r, c_a4_r;
  logic [2:0][7:0] c_rs_nxt, c_rd_nxt, c_rdd_nxt, c_rsd_nxt;
  logic [2:0][8:0] c_tr_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_rs_nxt[k]  = rdiv(b_ps_r[k]);
      c_rd_nxt[k]  = rdiv(b_pd_r[k]);
      c_rdd_nxt[k] = rdiv(b_pdd_r[k]);
      c_rsd_nxt[k] = rdiv(b_psd_r[k]);
      c_tr_nxt[k]  = div255_floor(17'(b_ps_r[k]) + 17'(b_pd_r[k]));
    end
  end

  // stage d: direct results and second dest product
  logic        d_valid_r, d_use_div_r;
  logic [31:0] d_direct_r;
  logic [7:0]  d_ra_r;
  logic [2:0][7:0]  d_spm_r;
  logic [2:0][15:0] d_m_r;
  logic [31:0] d_direct_nxt;
  logic        d_use_div_nxt;
  logic [2:0][7:0]  d_spm_nxt;
  logic [2:0][15:0] d_m_nxt;
  logic [7:0]  d_inv, d_da;
  logic [2:0][7:0] ch3, ch4, ch5, ch0;

  always_comb begin
    d_inv = CHAN_MAX - c_sa_r;
    d_da  = c_d_r[31:24];
    for (int k = 0; k < 3; k++) begin
      d_m_nxt[k]   = 16'(c_rdd_r[k]) * 16'(d_inv);
      d_spm_nxt[k] = (c_mode_r == MODE_STRAIGHT) ? c_rs_r[k] : c_s_r[8*k +: 8];
      ch0[k] = sat8(c_tr_r[k]);
      ch3[k] = sat8(9'(c_s_r[8*k +: 8]) + 9'(c_rd_r[k]));
      ch4[k] = sat8(9'(c_d_r[8*k +: 8]) + 9'(c_rsd_r[k]));
      ch5[k] = sat8(9'(c_rs_r[k]) + 9'(c_rd_r[k]));
    end
    d_use_div_nxt = 1'b0;
    d_direct_nxt  = c_d_r;
    case (c_mode_r)
      MODE_OPAQUE: begin
        if (c_sa_r == CHAN_MAX) d_direct_nxt = {CHAN_MAX, c_s_r[23:0]};
        else if (c_sa_r != 8'd0) d_direct_nxt = {CHAN_MAX, ch0[2], ch0[1], ch0[0]};
      end
      MODE_STRAIGHT: begin
        if (c_sa_r == CHAN_MAX) d_direct_nxt = c_s_r;
        else if (c_sa_r != 8'd0) d_use_div_nxt = 1'b1;
      end
      MODE_PREMULT: begin
        if (c_sa_r != 8'd0) d_use_div_nxt = 1'b1;
      end
      MODE_PREM_OPQ: begin
        if (c_sa_r == CHAN_MAX) d_direct_nxt = {CHAN_MAX, c_s_r[23:0]};
        else if (c_sa_r != 8'd0) d_direct_nxt = {sat8(c_ra_r), ch3[2], ch3[1], ch3[0]};
      end
      MODE_DEST_OVER: begin
        if (d_da != CHAN_MAX) d_direct_nxt = {sat8(c_a4_r), ch4[2], ch4[1], ch4[0]};
      end
      MODE_COVERAGE: begin
        if (c_sa_r != 8'd0) begin
          if (d_da == CHAN_MAX) d_direct_nxt = {CHAN_MAX, ch0[2], ch0[1], ch0[0]};
          else d_direct_nxt = {sat8(c_ra_r), ch5[2], ch5[1], ch5[0]};
        end
      end
      default: d_direct_nxt = c_d_r;
    endcase
  end

  // stage e: unpremultiply numerator
  dv_t e_r, e_nxt;
  logic [2:0][8:0] e_sum;

  always_comb begin
    e_nxt         = '0;
    e_nxt.valid   = d_valid_r;
    e_nxt.use_div = d_use_div_r;
    e_nxt.direct  = d_direct_r;
    e_nxt.ra      = d_ra_r;
    for (int k = 0; k < 3; k++) begin
      e_sum[k]     = 9'(d_spm_r[k]) + 9'(rdiv(d_m_r[k]));
      e_nxt.rem[k] = ({e_sum[k], 8'h00} - 17'(e_sum[k])) + 17'(d_ra_r >> 1);
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  dv_t dv_r   [DIV_STAGES];
  dv_t dv_src [DIV_STAGES];
  dv_t dv_nxt [DIV_STAGES];

  always_comb begin
    dv_src[0] = e_r;
    for (int j = 1; j < DIV_STAGES; j++) dv_src[j] = dv_r[j-1];
    for (int j = 0; j < DIV_STAGES; j++) begin
      dv_nxt[j] = dv_src[j];
      for (int k = 0; k < 3; k++) begin
        if (j == 0) dv_nxt[j].sat[k] = dv_src[j].rem[k] >= {1'b0, dv_src[j].ra, 8'h00};
        if (dv_src[j].rem[k] >= (17'(dv_src[j].ra) << (DIV_STAGES - 1 - j))) begin
          dv_nxt[j].rem[k] = dv_src[j].rem[k] - (17'(dv_src[j].ra) << (DIV_STAGES - 1 - j));
          dv_nxt[j].q[k][DIV_STAGES - 1 - j] = 1'b1;
        end
      end
    end
  end

  // output select
  dv_t        fin;
  logic [31:0] out_pixel_nxt;

  always_comb begin
    fin = dv_r[DIV_STAGES-1];
    if (!fin.use_div) begin
      out_pixel_nxt = fin.direct;
    end else if (fin.ra == 8'd0) begin
      out_pixel_nxt = '0;
    end else begin
      out_pixel_nxt = {fin.ra,
                       fin.sat[2] ? CHAN_MAX : fin.q[2],
                       fin.sat[1] ? CHAN_MAX : fin.q[1],
                       fin.sat[0] ? CHAN_MAX : fin.q[0]};
    end
  end

  // pipeline valid bits and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      e_r.valid   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < DIV_STAGES; j++) dv_r[j].valid <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= in_word.valid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r;
      out_valid_r <= fin.valid;

      a_d_r    <= in_word.dest_pixel;
      a_s_r    <= in_word.src_pixel;
      a_sa_r   <= a_sa_nxt;
      a_mode_r <= mode_r;

      b_d_r    <= a_d_r;
      b_s_r    <= a_s_r;
      b_sa_r   <= a_sa_r;
      b_mode_r <= a_mode_r;
      b_ps_r   <= b_ps_nxt;
      b_pd_r   <= b_pd_nxt;
      b_pdd_r  <= b_pdd_nxt;
      b_psd_r  <= b_psd_nxt;
      b_pa1_r  <= 16'(a_d_r[31:24]) * 16'(b_inv);
      b_pa2_r  <= 16'(a_s_r[31:24]) * 16'(b_ida);

      c_d_r    <= b_d_r;
      c_s_r    <= b_s_r;
      c_sa_r   <= b_sa_r;
      c_mode_r <= b_mode_r;
      c_rs_r   <= c_rs_nxt;
      c_rd_r   <= c_rd_nxt;
      c_rdd_r  <= c_rdd_nxt;
      c_rsd_r  <= c_rsd_nxt;
      c_tr_r   <= c_tr_nxt;
      c_ra_r   <= 9'(b_sa_r) + 9'(rdiv(b_pa1_r));
      c_a4_r   <= 9'(b_d_r[31:24]) + 9'(rdiv(b_pa2_r));

      d_use_div_r <= d_use_div_nxt;
      d_direct_r  <= d_direct_nxt;
      d_ra_r      <= sat8(c_ra_r);
      d_spm_r     <= d_spm_nxt;
      d_m_r       <= d_m_nxt;

      e_r <= e_nxt;

      for (int j = 0; j < DIV_STAGES; j++) dv_r[j] <= dv_nxt[j];

      out_pixel_r <= out_pixel_nxt;
    end
  end

  assign out_word.valid        = out_valid_r;
  assign out_word.result_pixel = out_pixel_r;

  // checks
  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({a_valid_r, b_valid_r, c_valid_r, d_valid_r, e_r.valid}))
    else $error("pipeline valid bits moved during a stall");

  a_div_ra_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (e_r.valid && e_r.use_div) |-> (e_r.ra != 8'd0))
    else $error("unpremultiply entered with zero result alpha");

  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid_r)
    else $error("output valid right after reset");

  a_in_ready_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word.ready) |-> !in_word.ready)
    else $error("input taken while output stalled");

endmodule
